@@ src/fsk_raised_cosine_bit_shaper_macros.svh @@
// Assertion helpers, all sampled on clk and disabled during rst.
`ifndef FSK_RAISED_COSINE_BIT_SHAPER_MACROS_SVH
`define FSK_RAISED_COSINE_BIT_SHAPER_MACROS_SVH

// Same-cycle implication.
`define FSKRC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FSKRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/fskrc_pkg.sv @@
package fskrc_pkg;

  localparam int PHASE_W = 24;
  localparam int STEP_W  = 25;
  localparam int AMP_W   = 15;
  localparam int MAG_W   = 16;
  localparam int REG_IDX_W = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_INVERT     = 2'd2;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = 25'd2796203;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RST  = 15'd32767;
  localparam logic [STEP_W-1:0] PHASE_ONE_TURN = 25'h1000000;

  // Q30 constants for the cosine table
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic [STEP_W-1:0] phase_step;
    logic [AMP_W-1:0]  amplitude;
    logic              invert;
  } cfg_t;

  typedef struct packed {
    logic load;     // latch a new bit, restart sample count
    logic step;     // produce one sample, advance phase
    logic advance;  // move the sample pipeline
  } cmd_t;

  typedef struct packed {
    logic done;     // current sample closes the bit period
  } status_t;

endpackage

@@ src/fsk_raised_cosine_bit_shaper.sv @@
// Pipeline: after a bit's s_ transaction, its samples pass the S1, S2, S3 and output
//   registers before m_tvalid rises for the first of them.
// Throughput: one sample per cycle with m_tready high; a bit of n samples (1..64)
//   holds s_tready low until its last sample is stepped, as the single phase accumulator
//   serves one bit at a time and only IDLE takes the next transaction.
// Reset: synchronous rst clears phase, previous bit (low), pipeline valids and
//   restores phase_step, amplitude and invert to their defaults.
`include "fsk_raised_cosine_bit_shaper_macros.svh"

module fsk_raised_cosine_bit_shaper #(
  parameter int RAMP_ENTRIES        = 256,
  parameter int MAX_SAMPLES_PER_BIT = 64,
  parameter int SAMPLE_BITS         = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [7:0]                             s_tdata,   // [0] bit_value
  // output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                                   m_tlast,   // last sample of the bit
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [fskrc_pkg::REG_IDX_W-1:0]        cfg_addr,
  input  logic [fskrc_pkg::STEP_W-1:0]           cfg_wdata
);

  localparam int OutW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [SAMPLE_BITS-1:0] MinNeg = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  fskrc_pkg::cfg_t    cfg;
  fskrc_pkg::cmd_t    cmd;
  fskrc_pkg::status_t sts;
  logic [SAMPLE_BITS-1:0] sample;

  fskrc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Controller: IDLE takes one bit, RUN emits one sample per advancing cycle
  // until the phase wraps or the sample cap is hit. Four valid bits track the
  // sample pipeline; the whole pipeline stalls on backpressure.
  fskrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: phase accumulator -> ramp lookup -> amplitude multiply -> sign.
  fskrc_dp #(
    .RAMP_ENTRIES        (RAMP_ENTRIES),
    .MAX_SAMPLES_PER_BIT (MAX_SAMPLES_PER_BIT),
    .SAMPLE_BITS         (SAMPLE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .cmd    (cmd),
    .sts    (sts),
    .in_bit (s_tdata[0]),
    .sample (sample),
    .last   (m_tlast)
  );

  assign m_tdata = OutW'(sample);

  `FSKRC_ASSERT_IMPL(a_no_step_when_idle, cmd.step, !s_tready, "sample generated while idle")
  `FSKRC_ASSERT_NEXT(a_done_to_idle, cmd.step && sts.done, s_tready, "bit end did not free input")
  `FSKRC_ASSERT_NEXT(a_load_to_run, cmd.load, !s_tready, "accepted bit did not start")
  `FSKRC_ASSERT_IMPL(a_sample_range, m_tvalid, sample != MinNeg, "sample out of range")

endmodule

@@ src/fskrc_regs.sv @@
module fskrc_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fskrc_pkg::REG_IDX_W-1:0]      cfg_addr,
  input  logic [fskrc_pkg::STEP_W-1:0]         cfg_wdata,
  output fskrc_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step <= fskrc_pkg::PHASE_STEP_RST;
      cfg.amplitude  <= fskrc_pkg::AMPLITUDE_RST;
      cfg.invert     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        fskrc_pkg::REG_PHASE_STEP: cfg.phase_step <= cfg_wdata;
        fskrc_pkg::REG_AMPLITUDE:  cfg.amplitude  <= cfg_wdata[fskrc_pkg::AMP_W-1:0];
        fskrc_pkg::REG_INVERT:     cfg.invert     <= cfg_wdata[0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

@@ src/fskrc_ctrl.sv @@
module fskrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  fskrc_pkg::status_t  sts,
  output fskrc_pkg::cmd_t     cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic       state;
  logic       state_next;
  logic [3:0] vld;   // S1, S2, S3, output register

  assign s_tready    = (state == ST_IDLE);
  assign m_tvalid    = vld[3];
  assign cmd.load    = s_tvalid && s_tready;
  assign cmd.advance = !vld[3] || m_tready;
  assign cmd.step    = (state == ST_RUN) && cmd.advance;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd.load) state_next = ST_RUN;
      ST_RUN:  if (cmd.step && sts.done) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vld   <= '0;
    end else begin
      state <= state_next;
      if (cmd.advance) vld <= {vld[2:0], cmd.step};
    end
  end

endmodule

@@ src/fskrc_dp.sv @@
module fskrc_dp #(
  parameter int RAMP_ENTRIES        = 256,
  parameter int MAX_SAMPLES_PER_BIT = 64,
  parameter int SAMPLE_BITS         = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  fskrc_pkg::cfg_t        cfg,
  input  fskrc_pkg::cmd_t        cmd,
  output fskrc_pkg::status_t     sts,
  input  logic                   in_bit,
  output logic [SAMPLE_BITS-1:0] sample,
  output logic                   last
);

  localparam int IdxW    = $clog2(RAMP_ENTRIES);
  localparam int Quarter = RAMP_ENTRIES / 4;
  localparam int Half    = RAMP_ENTRIES / 2;
  localparam int ThreeQ  = 3 * Quarter;
  localparam int QAddrW  = $clog2(Quarter + 1);
  localparam int CntW    = $clog2(MAX_SAMPLES_PER_BIT);
  localparam int ProdW   = fskrc_pkg::PHASE_W + IdxW + 1;
  localparam logic [31:0] AMaxV = 32'((1 << (SAMPLE_BITS - 1)) - 1);

  typedef logic [fskrc_pkg::MAG_W-1:0] qtab_t [Quarter+1];

  // cos(pi*t/(R/2)) in Q15 via 9-term Taylor series in Q30
  function automatic logic [fskrc_pkg::MAG_W-1:0] quarter_cos(input int t);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (fskrc_pkg::PI_Q30 * 64'(t) * 64'd2) / 64'(RAMP_ENTRIES);
    x2   = (x * x) >> 30;
    term = fskrc_pkg::ONE_Q30;
    acc  = $signed(fskrc_pkg::ONE_Q30);
    term = ((term * x2) >> 30) / 64'd2;   acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd12;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd30;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd56;  acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd90;  acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd132; acc = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd182; acc = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd240; acc = acc + $signed(term);
    if (acc < 0) acc = '0;
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 64'sd32768) acc = 64'sd32768;
    return acc[fskrc_pkg::MAG_W-1:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int t = 0; t <= Quarter; t++) tab[t] = quarter_cos(t);
    return tab;
  endfunction

  localparam qtab_t QTab = build_qtab();

  // sample generator state
  logic [fskrc_pkg::PHASE_W-1:0] phase_acc;
  logic                          level;
  logic                          bit_reg;
  logic [CntW-1:0]               cnt;

  logic [fskrc_pkg::STEP_W-1:0]  step_eff;
  logic [fskrc_pkg::STEP_W-1:0]  sum;
  logic [ProdW-1:0]              idx_prod;
  logic                          ramp;

  // pipeline registers
  logic [IdxW-1:0]               s1_idx;
  logic                          s1_ramp;
  logic                          s1_neg;
  logic                          s1_last;
  logic [fskrc_pkg::MAG_W-1:0]   s2_mag;
  logic                          s2_neg;
  logic                          s2_last;
  logic [fskrc_pkg::AMP_W-1:0]   s3_scaled;
  logic                          s3_neg;
  logic                          s3_last;

  logic [IdxW-1:0]               t_off;
  logic [IdxW-1:0]               qaddr;
  logic [fskrc_pkg::MAG_W-1:0]   s1_mag;
  logic                          s1_flip;
  logic [fskrc_pkg::AMP_W-1:0]   amp_sat;
  logic [31:0]                   scale_prod;
  logic signed [SAMPLE_BITS-1:0] s3_val;

  // stage 0: phase step and ROM index
  assign step_eff = cfg.phase_step[fskrc_pkg::STEP_W-1] ? fskrc_pkg::PHASE_ONE_TURN
                                                         : cfg.phase_step;
  assign sum      = {1'b0, phase_acc} + step_eff;
  assign sts.done = sum[fskrc_pkg::STEP_W-1] || (cnt == CntW'(MAX_SAMPLES_PER_BIT - 1));
  assign idx_prod = ProdW'(phase_acc) * ProdW'(RAMP_ENTRIES);
  assign ramp     = (bit_reg != level);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      level     <= 1'b0;
      cnt       <= '0;
    end else if (cmd.load) begin
      cnt <= '0;
    end else if (cmd.step) begin
      phase_acc <= sum[fskrc_pkg::PHASE_W-1:0];
      cnt       <= cnt + 1'b1;
      if (sts.done) level <= bit_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) bit_reg <= in_bit;
  end

  // stage 1: ramp table lookup with quarter-wave symmetry
  always_comb begin
    t_off   = s1_idx - IdxW'(Quarter);
    qaddr   = t_off;
    s1_mag  = 16'h8000;
    s1_flip = 1'b0;
    if (s1_ramp) begin
      if (s1_idx < IdxW'(Quarter)) begin
        s1_flip = 1'b0;
      end else if (s1_idx >= IdxW'(ThreeQ)) begin
        s1_flip = 1'b1;
      end else begin
        if (t_off <= IdxW'(Quarter)) begin
          qaddr = t_off;
        end else begin
          qaddr   = IdxW'(Half) - t_off;
          s1_flip = 1'b1;
        end
        s1_mag = QTab[qaddr[QAddrW-1:0]];
      end
    end
  end

  // stage 2: amplitude scaling, rounded
  assign amp_sat    = (32'(cfg.amplitude) > AMaxV) ? AMaxV[fskrc_pkg::AMP_W-1:0]
                                                   : cfg.amplitude;
  assign scale_prod = 32'(s2_mag) * 32'(amp_sat) + 32'd16384;

  // stage 3: sign
  assign s3_val = s3_neg ? -$signed(SAMPLE_BITS'(s3_scaled)) : $signed(SAMPLE_BITS'(s3_scaled));

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      s1_idx    <= idx_prod[fskrc_pkg::PHASE_W +: IdxW];
      s1_ramp   <= ramp;
      s1_neg    <= ramp ? bit_reg : !bit_reg;
      s1_last   <= sts.done;
      s2_mag    <= s1_mag;
      s2_neg    <= s1_neg ^ s1_flip;
      s2_last   <= s1_last;
      s3_scaled <= scale_prod[15 +: fskrc_pkg::AMP_W];
      s3_neg    <= s2_neg ^ cfg.invert;
      s3_last   <= s2_last;
      sample    <= s3_val;
      last      <= s3_last;
    end
  end

endmodule
